/* src/sync_length_fletcher_deframer_top_defines.svh */
// ----------------------------------------------------------------------------
// sync_length_fletcher_deframer_top_defines.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FLETCHER_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_FLETCHER_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define SLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

/* src/sld_pkg.sv */
// ----------------------------------------------------------------------------
// sld_pkg
// Types, register codes and the mod-255 adder of the sync/length deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sld_pkg;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_ID,
		PH_LEN,
		PH_BODY
	} phase_t;

	localparam logic [1:0] CFG_SYNC_VALUE = 2'd0;
	localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;
	localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

	localparam logic [15:0] TALLY_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] sync_value;
		logic [7:0] min_length;
		logic [8:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  packet_id;
		logic [7:0]  packet_length;
		logic [7:0]  byte_index;
		logic [7:0]  data_byte;
		logic        last;
		logic        checksum_ok;
		logic [15:0] bad_checksum_count;
	} result_t;

	function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 9'd255)
			s = s - 9'd255;
		return s[7:0];
	endfunction

endpackage

/* src/sld_frame.sv */
// ----------------------------------------------------------------------------
// sld_frame
// Framing state machine with Fletcher-16 sums; one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sld_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  sld_pkg::cfg_t    cfg,
	input  logic             step,
	input  logic [7:0]       byte_in,
	output logic             has_result,
	output sld_pkg::result_t result
);
	import sld_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  held_id_q, held_id_d;
	logic [7:0]  held_length_q, held_length_d;
	logic [7:0]  position_q, position_d;
	logic [7:0]  sum_lo_q, sum_lo_d;
	logic [7:0]  sum_hi_q, sum_hi_d;
	logic [7:0]  check_lo_q, check_lo_d;
	logic [15:0] tally_q, tally_d;

	logic        len_ok;
	logic        last_c;
	logic        ok_c;
	logic [7:0]  index_c;

	assign len_ok = (byte_in >= 8'd3) && (byte_in >= cfg.min_length)
		&& ({1'b0, byte_in} < cfg.max_length);

	always_comb begin
		phase_d       = phase_q;
		held_id_d     = held_id_q;
		held_length_d = held_length_q;
		position_d    = position_q;
		sum_lo_d      = sum_lo_q;
		sum_hi_d      = sum_hi_q;
		check_lo_d    = check_lo_q;
		tally_d       = tally_q;
		has_result    = 1'b0;
		last_c        = 1'b0;
		ok_c          = 1'b0;
		index_c       = position_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_in == cfg.sync_value)
					phase_d = PH_ID;
			end
			PH_ID: begin
				held_id_d = byte_in;
				phase_d   = PH_LEN;
			end
			PH_LEN: begin
				if (len_ok) begin
					held_length_d = byte_in;
					sum_lo_d      = mod255_add(8'd0, cfg.sync_value);
					sum_hi_d      = sum_lo_d;
					if (byte_in >= 8'd4) begin
						sum_lo_d = mod255_add(sum_lo_d, held_id_q);
						sum_hi_d = mod255_add(sum_hi_d, sum_lo_d);
					end
					if (byte_in >= 8'd5) begin
						sum_lo_d = mod255_add(sum_lo_d, byte_in);
						sum_hi_d = mod255_add(sum_hi_d, sum_lo_d);
					end
					if (byte_in == 8'd3)
						check_lo_d = held_id_q;
					else if (byte_in == 8'd4)
						check_lo_d = byte_in;
					position_d = 8'd3;
					phase_d    = PH_BODY;
					has_result = 1'b1;
					index_c    = 8'd2;
					last_c     = (byte_in == 8'd3);
				end else if (held_id_q == cfg.sync_value) begin
					held_id_d = byte_in;
					phase_d   = PH_LEN;
				end else if (byte_in == cfg.sync_value) begin
					phase_d = PH_ID;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				position_d = position_q + 8'd1;
				if (({1'b0, position_q} + 9'd3) <= {1'b0, held_length_q}) begin
					sum_lo_d = mod255_add(sum_lo_q, byte_in);
					sum_hi_d = mod255_add(sum_hi_q, sum_lo_d);
				end else if (({1'b0, position_q} + 9'd2) == {1'b0, held_length_q}) begin
					check_lo_d = byte_in;
				end
				has_result = 1'b1;
				last_c     = (({1'b0, position_q} + 9'd1) == {1'b0, held_length_q});
			end
			default: phase_d = PH_HUNT;
		endcase
		if (has_result && last_c) begin
			ok_c    = (check_lo_d == sum_lo_d) && (byte_in == sum_hi_d);
			phase_d = PH_HUNT;
			if (!ok_c && (tally_q != TALLY_MAX))
				tally_d = tally_q + 16'd1;
		end
	end

	always_comb begin
		result.packet_id          = held_id_d;
		result.packet_length      = held_length_d;
		result.byte_index         = index_c;
		result.data_byte          = byte_in;
		result.last               = last_c;
		result.checksum_ok        = ok_c;
		result.bad_checksum_count = tally_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			held_id_q     <= 8'd0;
			held_length_q <= 8'd0;
			position_q    <= 8'd0;
			sum_lo_q      <= 8'd0;
			sum_hi_q      <= 8'd0;
			check_lo_q    <= 8'd0;
			tally_q       <= 16'd0;
		end else if (step) begin
			phase_q       <= phase_d;
			held_id_q     <= held_id_d;
			held_length_q <= held_length_d;
			position_q    <= position_d;
			sum_lo_q      <= sum_lo_d;
			sum_hi_q      <= sum_hi_d;
			check_lo_q    <= check_lo_d;
			tally_q       <= tally_d;
		end
	end

endmodule

/* src/sync_length_fletcher_deframer_top.sv */
// ----------------------------------------------------------------------------
// sync_length_fletcher_deframer_top
// Sync/length framed packet deframer with Fletcher-16 check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one received byte (rx_byte) per
//   transfer. The block hunts for sync_value, takes id and length bytes and
//   forwards bytes 2 .. length-1 on the output channel out_valid/out_ready,
//   tagged with id, length and index. The final byte has last set and
//   checksum_ok reports the Fletcher-16 compare; failures are counted in
//   bad_checksum_count (saturating).
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//   sync_value (0), min_length (1) or max_length (2); cfg_ready is always 1.
//   Write only while the block is idle.
//   Timing: one byte per cycle while the receiver keeps up; a byte goes
//   through an input register and then the result register, which offers
//   its result on the output channel. The framing logic between the two
//   registers is a single pass.
//   Reset (arst_n low) clears all framing state and the failure count and
//   restores register defaults 0 / 5 / 256.
//   When the receiver stalls, the result register holds; the input register
//   keeps taking bytes that give no result, and in_ready drops once a
//   byte with a result waits behind the full result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_length_fletcher_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packet_id,
	output logic [7:0]  packet_length,
	output logic [7:0]  byte_index,
	output logic [7:0]  data_byte,
	output logic        last,
	output logic        checksum_ok,
	output logic [15:0] bad_checksum_count
);
	import sld_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_result;
	result_t    result;
	logic       advance;
	logic       out_valid_q;
	result_t    out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value <= 8'd0;
			cfg_q.min_length <= 8'd5;
			cfg_q.max_length <= 9'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SYNC_VALUE: cfg_q.sync_value <= cfg_data[7:0];
				CFG_MIN_LENGTH: cfg_q.min_length <= cfg_data[7:0];
				CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	sld_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step       (advance),
		.byte_in    (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && has_result)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && has_result)
			out_q <= result;
	end

	assign out_valid          = out_valid_q;
	assign packet_id          = out_q.packet_id;
	assign packet_length      = out_q.packet_length;
	assign byte_index         = out_q.byte_index;
	assign data_byte          = out_q.data_byte;
	assign last               = out_q.last;
	assign checksum_ok        = out_q.checksum_ok;
	assign bad_checksum_count = out_q.bad_checksum_count;

endmodule

/* src/sld_checker.sv */
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks of the deframer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_fletcher_deframer_top_defines.svh"

module sld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  packet_id,
	input logic [7:0]  packet_length,
	input logic [7:0]  byte_index,
	input logic [7:0]  data_byte,
	input logic        last,
	input logic        checksum_ok,
	input logic [15:0] bad_checksum_count
);

	`SLD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(byte_index) && $stable(packet_id))
	`SLD_ASSERT_NEXT(a_tag_hold, clk, arst_n, out_valid && !out_ready, $stable(packet_length) && $stable(last) && $stable(checksum_ok) && $stable(bad_checksum_count))
	`SLD_ASSERT_NOW(a_ok_only_last, clk, arst_n, out_valid && !last, !checksum_ok)
	`SLD_ASSERT_NOW(a_index_range, clk, arst_n, out_valid, (byte_index >= 8'd2) && (byte_index < packet_length))
	`SLD_ASSERT_NOW(a_last_pos, clk, arst_n, out_valid && last, ({1'b0, byte_index} + 9'd1) == {1'b0, packet_length})

endmodule

bind sync_length_fletcher_deframer_top sld_checker u_sld_checker (.*);

/* sim/sld_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_frame_checker
// Watches the register, byte and result channels of the sync/length deframer.
// Keeps its own copy of the framing state and registers, works out the
// forwarded bytes, checksum verdicts and failure count for every accepted
// input byte, and compares each result transfer field by field against the
// oldest expected one. Mismatches are counted and handed to the testbench.
// ----------------------------------------------------------------------------

module sld_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  packet_id,
	input  logic [7:0]  packet_length,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        checksum_ok,
	input  logic [15:0] bad_checksum_count,
	output int          mismatches,
	output int          pending,
	output int          results_seen,
	output int          packets_ok,
	output int          packets_bad
);
	import sld_pkg::*;

	logic [7:0]  sync_byte_cfg;
	logic [7:0]  min_len_cfg;
	logic [8:0]  max_len_cfg;

	phase_t      frame_phase;
	logic [7:0]  hdr_id;
	logic [7:0]  hdr_len;
	logic [7:0]  next_index;
	logic [7:0]  sum_a;
	logic [7:0]  sum_b;
	logic [7:0]  check_lo;
	logic [15:0] fail_tally;

	result_t     expected_bytes [$];

	function automatic void fold_byte(input logic [7:0] v);
		logic [8:0] s;
		s = {1'b0, sum_a} + {1'b0, v};
		sum_a = 8'(s % 9'd255);
		s = {1'b0, sum_b} + {1'b0, sum_a};
		sum_b = 8'(s % 9'd255);
	endfunction

	function automatic result_t tag_byte(input logic [7:0] idx, input logic [7:0] b,
			input logic is_last);
		result_t r;
		r = '0;
		if (is_last) begin
			r.checksum_ok = (check_lo == sum_a) && (b == sum_b);
			if (!r.checksum_ok && fail_tally != TALLY_MAX)
				fail_tally = fail_tally + 16'd1;
			frame_phase = PH_HUNT;
		end
		r.packet_id = hdr_id;
		r.packet_length = hdr_len;
		r.byte_index = idx;
		r.data_byte = b;
		r.last = is_last;
		r.bad_checksum_count = fail_tally;
		return r;
	endfunction

	function automatic bit frame_byte(input logic [7:0] b, output result_t r);
		int idx;
		int len;
		r = '0;
		case (frame_phase)
			PH_HUNT: begin
				if (b == sync_byte_cfg)
					frame_phase = PH_ID;
				return 1'b0;
			end
			PH_ID: begin
				hdr_id = b;
				frame_phase = PH_LEN;
				return 1'b0;
			end
			PH_LEN: begin
				if (b >= 8'd3 && b >= min_len_cfg && {1'b0, b} < max_len_cfg) begin
					hdr_len = b;
					sum_a = '0;
					sum_b = '0;
					fold_byte(sync_byte_cfg);
					if (b >= 8'd4)
						fold_byte(hdr_id);
					if (b >= 8'd5)
						fold_byte(b);
					if (b == 8'd3)
						check_lo = hdr_id;
					else if (b == 8'd4)
						check_lo = b;
					next_index = 8'd3;
					frame_phase = PH_BODY;
					r = tag_byte(8'd2, b, b == 8'd3);
					return 1'b1;
				end
				if (hdr_id == sync_byte_cfg)
					hdr_id = b;
				else if (b == sync_byte_cfg)
					frame_phase = PH_ID;
				else
					frame_phase = PH_HUNT;
				return 1'b0;
			end
			default: begin
				idx = next_index;
				len = hdr_len;
				next_index = next_index + 8'd1;
				if (idx + 3 <= len)
					fold_byte(b);
				else if (idx + 2 == len)
					check_lo = b;
				r = tag_byte(8'(idx), b, idx + 1 == len);
				return 1'b1;
			end
		endcase
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("id=%02h len=%0d idx=%0d byte=%02h last=%0b ok=%0b bad=%0d",
			r.packet_id, r.packet_length, r.byte_index, r.data_byte, r.last,
			r.checksum_ok, r.bad_checksum_count);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		result_t pred;
		if (!arst_n) begin
			sync_byte_cfg = 8'd0;
			min_len_cfg = 8'd5;
			max_len_cfg = 9'd256;
			frame_phase = PH_HUNT;
			hdr_id = '0;
			hdr_len = '0;
			next_index = '0;
			sum_a = '0;
			sum_b = '0;
			check_lo = '0;
			fail_tally = '0;
			expected_bytes.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				got = {packet_id, packet_length, byte_index, data_byte, last, checksum_ok,
					bad_checksum_count};
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected: %s", $time, show(got));
				end else begin
					want = expected_bytes.pop_front();
					if (want.last) begin
						if (want.checksum_ok)
							packets_ok++;
						else
							packets_bad++;
					end
					if (got.packet_id !== want.packet_id
							|| got.packet_length !== want.packet_length
							|| got.byte_index !== want.byte_index
							|| got.data_byte !== want.data_byte
							|| got.last !== want.last
							|| got.checksum_ok !== want.checksum_ok
							|| got.bad_checksum_count !== want.bad_checksum_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result differs\n  expected %s\n  actual   %s",
								$time, show(want), show(got));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SYNC_VALUE: sync_byte_cfg = cfg_data[7:0];
					CFG_MIN_LENGTH: min_len_cfg = cfg_data[7:0];
					CFG_MAX_LENGTH: max_len_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (frame_byte(rx_byte, pred))
					expected_bytes.push_back(pred);
			end
			pending = expected_bytes.size();
		end
	end

endmodule

/* sim/tb_sync_length_fletcher_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_fletcher_deframer_top
// Feeds the deframer a byte stream of framed packets, stray bytes and
// rejected headers under a series of sync/length register settings, with
// random gaps on the byte side and random stalls on the result side. A short
// hand-built opening covers header recovery and the short-length packets.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------

module tb_sync_length_fletcher_deframer_top;
	import sld_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [0:13][7:0] OPENING = {
		8'hFF, 8'h02, 8'h02, 8'h01, 8'h03, 8'h02, 8'h07,
		8'h02, 8'h09, 8'h04, 8'h5C, 8'h02, 8'h33, 8'h00
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  packet_id;
	logic [7:0]  packet_length;
	logic [7:0]  byte_index;
	logic [7:0]  data_byte;
	logic        last;
	logic        checksum_ok;
	logic [15:0] bad_checksum_count;

	int mismatches;
	int pending;
	int results_seen;
	int packets_ok;
	int packets_bad;

	logic [7:0] sync_cfg;
	logic [7:0] min_cfg;
	logic [8:0] max_cfg;
	bit         calm;
	int         run_left;
	int         stall_left;
	int         items_sent;
	int         settings;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	sync_length_fletcher_deframer_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.rx_byte            (rx_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.packet_id          (packet_id),
		.packet_length      (packet_length),
		.byte_index         (byte_index),
		.data_byte          (data_byte),
		.last               (last),
		.checksum_ok        (checksum_ok),
		.bad_checksum_count (bad_checksum_count)
	);

	sld_frame_checker frame_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.rx_byte            (rx_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.packet_id          (packet_id),
		.packet_length      (packet_length),
		.byte_index         (byte_index),
		.data_byte          (data_byte),
		.last               (last),
		.checksum_ok        (checksum_ok),
		.bad_checksum_count (bad_checksum_count),
		.mismatches         (mismatches),
		.pending            (pending),
		.results_seen       (results_seen),
		.packets_ok         (packets_ok),
		.packets_bad        (packets_bad)
	);

	// result-side stalls: mostly short runs and stalls, a few long ones
	always @(negedge clk) begin
		if (!arst_n) begin
			run_left = 0;
			stall_left = 0;
			out_ready <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 7);
			case ($urandom_range(0, 19))
				0: stall_left = $urandom_range(15, 40);
				1, 2, 3, 4: stall_left = $urandom_range(4, 10);
				default: stall_left = $urandom_range(0, 3);
			endcase
			out_ready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SYNC_VALUE: sync_cfg = val[7:0];
			CFG_MIN_LENGTH: min_cfg = val[7:0];
			CFG_MAX_LENGTH: max_cfg = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [7:0] s, input logic [7:0] mn, input logic [8:0] mx,
			input bit poke_unused);
		write_reg(CFG_SYNC_VALUE, {1'($urandom_range(0, 1)), s});
		write_reg(CFG_MIN_LENGTH, {1'($urandom_range(0, 1)), mn});
		write_reg(CFG_MAX_LENGTH, mx);
		if (poke_unused)
			write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// hold off until every result is in and the input stage has settled
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic send_packet(input int len, input bit corrupt, input logic [7:0] id);
		logic [7:0] pkt [256];
		int lo_sum;
		int hi_sum;
		int i;
		int pick;
		pkt[0] = sync_cfg;
		pkt[1] = id;
		pkt[2] = 8'(len);
		for (i = 3; i < len; i++)
			pkt[i] = 8'($urandom_range(0, 255));
		lo_sum = 0;
		hi_sum = 0;
		for (i = 0; i <= len - 3; i++) begin
			lo_sum = (lo_sum + pkt[i]) % 255;
			hi_sum = (hi_sum + lo_sum) % 255;
		end
		if (len >= 5)
			pkt[len - 2] = 8'(lo_sum);
		if (len >= 4)
			pkt[len - 1] = 8'(hi_sum);
		if (corrupt) begin
			pick = (len > 3) ? $urandom_range(3, len - 1) : 1;
			pkt[pick][$urandom_range(0, 7)] ^= 1'b1;
		end
		for (i = 0; i < len; i++)
			push_byte(pkt[i]);
	endtask

	task automatic send_rejected();
		int bad;
		case ($urandom_range(0, 2))
			0: bad = $urandom_range(0, 2);
			1: bad = (min_cfg > 8'd3) ? $urandom_range(3, int'(min_cfg) - 1)
				: $urandom_range(0, 2);
			default: bad = (max_cfg <= 9'd255) ? $urandom_range(int'(max_cfg), 255)
				: $urandom_range(0, 2);
		endcase
		push_byte(sync_cfg);
		push_byte(8'($urandom_range(0, 255)));
		push_byte(8'(bad));
	endtask

	task automatic random_phase(input logic [7:0] s, input logic [7:0] mn,
			input logic [8:0] mx, input bit poke_unused, input int budget);
		int lo;
		int hi;
		int len;
		int r;
		int done;
		configure(s, mn, mx, poke_unused);
		lo = (mn < 8'd3) ? 3 : int'(mn);
		hi = (mx > 9'd256) ? 255 : int'(mx) - 1;
		done = 0;
		while (done < budget) begin
			calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_byte(8'($urandom_range(0, 255)));
			end else if (r < 15 || lo > hi) begin
				send_rejected();
				done += 3;
			end else begin
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(lo, hi);
				else
					len = $urandom_range(lo, (hi - lo > 10) ? lo + 10 : hi);
				send_packet(len, $urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
				done += len;
			end
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		logic [7:0] mn;
		int k;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		calm = 1'b0;
		items_sent = 0;
		settings = 0;
		sync_cfg = 8'd0;
		min_cfg = 8'd5;
		max_cfg = 9'd256;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		configure(8'h02, 8'd3, 9'd256, 1'b0);
		for (k = 0; k < 14; k++)
			push_byte(OPENING[k]);
		send_packet(5, 1'b0, 8'h00);
		send_packet(6, 1'b1, 8'hFF);
		drain();

		random_phase(8'h00, 8'd3, 9'd4, 1'b0, 150);
		random_phase(8'hFF, 8'd5, 9'd256, 1'b0, 170);
		random_phase(8'($urandom_range(0, 255)), 8'd3, 9'd20, 1'b1, 150);
		random_phase(8'h5A, 8'd255, 9'd256, 1'b0, 250);
		mn = 8'($urandom_range(3, 40));
		random_phase(8'($urandom_range(0, 255)), mn, {1'b0, mn} + 9'($urandom_range(1, 30)),
			1'b0, 200);
		random_phase(8'h00, 8'd5, 9'd256, 1'b1, 200);
		random_phase(8'($urandom_range(0, 255)), 8'd3, 9'd256, 1'b0, 120);
		random_phase(8'($urandom_range(0, 255)), 8'd3, 9'd256, 1'b0, 40);

		$display("Sent %0d bytes under %0d register settings; %0d results checked.",
			items_sent, settings, results_seen);
		$display("Packets with good sum: %0d, with bad sum: %0d; mismatches: %0d.",
			packets_ok, packets_bad, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#24_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
